### sv/gfe_pkg.sv
// Shared types, constants and frame check function for the GDL90 frame encoder.
package gfe_pkg;

  // Framing bytes and the stuffing mask.
  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_MASK  = 8'h20;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  // Output sequencer phases, one per emitted byte slot.
  typedef enum logic [2:0] {
    PH_OPEN,
    PH_DATA,
    PH_DATA_ESC,
    PH_CRCL,
    PH_CRCL_ESC,
    PH_CRCH,
    PH_CRCH_ESC,
    PH_CLOSE
  } phase_t;

  // One accepted byte, ready for the output sequencer.
  typedef struct packed {
    logic        open_frame;
    logic [7:0]  data;
    logic        last;
    logic [15:0] crc;
  } job_t;

  // True for bytes that must be escaped on the link.
  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  // CRC-16-CCITT byte update, MSB first: table entry of the high byte,
  // then the low byte moved up and the new byte folded in.
  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = {c[15:8], 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v ^ {c[7:0], 8'h00} ^ {8'h00, b};
  endfunction

endpackage

### sv/gfe_front.sv
// Input stage: accepts message bytes, keeps the running check and frame state.
module gfe_front import gfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte[7:0]
  input  logic       s_tlast,   // last_byte
  output logic       job_valid,
  output job_t       job,
  input  logic       job_pop
);

  logic [15:0] check_value;
  logic        inside_frame;
  logic [15:0] crc_next;
  logic        accept;

  // The job register frees up in the same cycle its final byte is emitted.
  assign s_tready = !job_valid || job_pop;
  assign accept   = s_tvalid && s_tready;

  // A new frame starts its check from zero.
  assign crc_next = crc_update(inside_frame ? check_value : 16'h0000, s_tdata);

  // Frame state and job valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      check_value  <= 16'h0000;
      inside_frame <= 1'b0;
      job_valid    <= 1'b0;
    end else begin
      if (accept) begin
        job_valid <= 1'b1;
        if (s_tlast) begin
          check_value  <= 16'h0000;
          inside_frame <= 1'b0;
        end else begin
          check_value  <= crc_next;
          inside_frame <= 1'b1;
        end
      end else if (job_pop) begin
        job_valid <= 1'b0;
      end
    end
  end

  // Job payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      job.open_frame <= !inside_frame;
      job.data       <= s_tdata;
      job.last       <= s_tlast;
      job.crc        <= crc_next;
    end
  end

endmodule

### sv/gfe_stuffer.sv
// Output sequencer: a job's stuffed byte, opening flag first if due, check and closing flag if last.
module gfe_stuffer import gfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte[7:0]
  output logic       m_tlast,   // run_last
  output logic       m_tuser    // frame_end
);

  phase_t     phase, phase_next, eff_phase;
  logic       advance;
  logic [7:0] cur_byte;
  logic       cur_done;
  logic       cur_end;

  // The opening flag slot is skipped when the frame is already open.
  assign eff_phase = (phase == PH_OPEN && !job.open_frame) ? PH_DATA : phase;

  // The output register takes a byte whenever it is empty or being drained.
  assign advance = job_valid && (!m_tvalid || m_tready);
  assign job_pop = advance && cur_done;

  // Next phase.
  always_comb begin
    case (eff_phase)
      PH_OPEN:     phase_next = PH_DATA;
      PH_DATA: begin
        if (needs_esc(job.data)) phase_next = PH_DATA_ESC;
        else if (job.last)       phase_next = PH_CRCL;
        else                     phase_next = PH_OPEN;
      end
      PH_DATA_ESC: phase_next = job.last ? PH_CRCL : PH_OPEN;
      PH_CRCL:     phase_next = needs_esc(job.crc[7:0]) ? PH_CRCL_ESC : PH_CRCH;
      PH_CRCL_ESC: phase_next = PH_CRCH;
      PH_CRCH:     phase_next = needs_esc(job.crc[15:8]) ? PH_CRCH_ESC : PH_CLOSE;
      PH_CRCH_ESC: phase_next = PH_CLOSE;
      PH_CLOSE:    phase_next = PH_OPEN;
      default:     phase_next = PH_OPEN;
    endcase
  end

  // Byte and marks for the current slot.
  always_comb begin
    cur_done = 1'b0;
    cur_end  = 1'b0;
    case (eff_phase)
      PH_OPEN:     cur_byte = FLAG_BYTE;
      PH_DATA: begin
        cur_byte = needs_esc(job.data) ? ESC_BYTE : job.data;
        cur_done = !needs_esc(job.data) && !job.last;
      end
      PH_DATA_ESC: begin
        cur_byte = job.data ^ ESC_MASK;
        cur_done = !job.last;
      end
      PH_CRCL:     cur_byte = needs_esc(job.crc[7:0]) ? ESC_BYTE : job.crc[7:0];
      PH_CRCL_ESC: cur_byte = job.crc[7:0] ^ ESC_MASK;
      PH_CRCH:     cur_byte = needs_esc(job.crc[15:8]) ? ESC_BYTE : job.crc[15:8];
      PH_CRCH_ESC: cur_byte = job.crc[15:8] ^ ESC_MASK;
      PH_CLOSE: begin
        cur_byte = FLAG_BYTE;
        cur_done = 1'b1;
        cur_end  = 1'b1;
      end
      default:     cur_byte = FLAG_BYTE;
    endcase
  end

  // Phase register and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_OPEN;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        phase    <= phase_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= cur_byte;
      m_tlast <= cur_done;
      m_tuser <= cur_end;
    end
  end

`ifndef SYNTHESIS
  // A job in mid-expansion must not lose its source.
  assert property (@(posedge clk) disable iff (rst) phase != PH_OPEN |-> job_valid)
    else $error("gfe_stuffer: sequencer mid-job without a job");

  // The closing flag always ends the run of its input byte.
  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tuser |-> m_tlast)
    else $error("gfe_stuffer: frame end without run end");

  // The closing flag carries the flag value.
  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tuser |-> m_tdata == FLAG_BYTE)
    else $error("gfe_stuffer: frame end on a non-flag byte");

  // Finishing a job returns the sequencer to its start phase.
  assert property (@(posedge clk) disable iff (rst) job_pop |=> phase == PH_OPEN)
    else $error("gfe_stuffer: job finished in mid-sequence");
`endif

endmodule

### sv/gdl90_frame_encoder.sv
// Top level of the GDL90 frame encoder: framing, byte stuffing and CRC-16.
//
//   channel  direction  tdata           tlast       tuser
//   s_*      in         data_byte[7:0]  last_byte   -
//   m_*      out        out_byte[7:0]   run_last    frame_end
//
// Each input byte yields 1 to 8 output bytes, one per cycle through the output register.
// A byte inside a frame gives 1 output byte, or 2 when escaped; the first byte of a
// frame adds the opening flag, the last adds 3 to 5 bytes for check and closing flag.
// The next input transaction is taken in the cycle the current job emits its final byte.
// Reset clears the frame state, the check and both valid flags.
// Output stalls hold the sequencer; the single job register stalls the input side.
module gdl90_frame_encoder import gfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte[7:0]
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte[7:0]
  output logic       m_tlast,   // run_last
  output logic       m_tuser    // frame_end
);

  logic job_valid;
  job_t job;
  logic job_pop;

  gfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  gfe_stuffer u_stuffer (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

### sim/tb.sv
// Self-checking testbench for the GDL90 frame encoder: directed table, then random messages.
`timescale 1ns / 1ps

module tb import gfe_pkg::*; ();

  // One byte of the framed link stream, as seen on the master side.
  typedef struct packed {
    logic [7:0] octet;
    logic       run_last;
    logic       frame_end;
  } link_byte_t;

  // One directed transaction; hand_n > 0 means the link bytes are typed in.
  typedef struct packed {
    logic [7:0]  d;
    logic        l;
    logic [3:0]  hand_n;
    logic [63:0] hand;
  } dir_row_t;

  localparam int N_DIR     = 22;
  localparam int N_RANDOM  = 200;
  localparam int HOLD_LEN  = 150;
  localparam int HOLD_AT   = 80;
  localparam int MAX_SHOWN = 20;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // data_byte[7:0]
  logic       s_tlast;   // last_byte
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // out_byte[7:0]
  logic       m_tlast;   // run_last
  logic       m_tuser;   // frame_end

  // Predictor state: open frame flag and running frame check.
  logic [15:0] fcs_acc;
  logic        frame_open;

  link_byte_t  link_q[$];
  link_byte_t  seq_q[$];
  int          errors;
  int          bytes_in;
  int          bytes_out;
  int          frames_closed;
  int          escapes_seen;
  int          burst_left;

  // Single-byte messages are read off directly: flag, byte, check low (= byte), zero, flag.
  dir_row_t dir_tab [N_DIR] = '{
    '{8'h00, 1'b1, 4'd5, 64'h7E00_0000_7E00_0000},
    '{8'hFF, 1'b1, 4'd5, 64'h7EFF_FF00_7E00_0000},
    '{8'h7E, 1'b1, 4'd7, 64'h7E7D_5E7D_5E00_7E00},
    '{8'h7D, 1'b1, 4'd7, 64'h7E7D_5D7D_5D00_7E00},
    '{8'h5E, 1'b1, 4'd5, 64'h7E5E_5E00_7E00_0000},
    '{8'h80, 1'b1, 4'd5, 64'h7E80_8000_7E00_0000},
    '{8'h7E, 1'b0, 4'd0, 64'h0},
    '{8'h7D, 1'b1, 4'd0, 64'h0},
    '{8'h7D, 1'b0, 4'd0, 64'h0},
    '{8'h7E, 1'b1, 4'd0, 64'h0},
    '{8'h01, 1'b0, 4'd0, 64'h0},
    '{8'h02, 1'b0, 4'd0, 64'h0},
    '{8'h80, 1'b0, 4'd0, 64'h0},
    '{8'hFF, 1'b0, 4'd0, 64'h0},
    '{8'h00, 1'b1, 4'd0, 64'h0},
    '{8'h55, 1'b0, 4'd0, 64'h0},
    '{8'hAA, 1'b0, 4'd0, 64'h0},
    '{8'h7E, 1'b0, 4'd0, 64'h0},
    '{8'h7E, 1'b0, 4'd0, 64'h0},
    '{8'h7D, 1'b1, 4'd0, 64'h0},
    '{8'h20, 1'b0, 4'd0, 64'h0},
    '{8'h5D, 1'b1, 4'd0, 64'h0}
  };

  gdl90_frame_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // High byte of the check folded through the polynomial, one bit at a time.
  function automatic logic [15:0] poly_fold(input logic [7:0] h);
    logic [15:0] r;
    logic        fb;
    r = 16'h0000;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ h[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ 16'h1021;
      end
    end
    return r;
  endfunction

  // Running check update: folded high byte, low byte moved up, new byte in the bottom.
  function automatic logic [15:0] fcs_next(input logic [15:0] c, input logic [7:0] b);
    return poly_fold(c[15:8]) ^ {c[7:0], 8'h00} ^ {8'h00, b};
  endfunction

  function automatic void seq_push(input logic [7:0] b, input logic fe);
    link_byte_t lb;
    lb = '{b, 1'b0, fe};
    seq_q.insert(seq_q.size(), lb);
  endfunction

  // A flag or escape byte on the link becomes the escape byte plus the byte with bit 5 flipped.
  function automatic void seq_push_stuffed(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      seq_push(ESC_BYTE, 1'b0);
      seq_push(b ^ ESC_MASK, 1'b0);
    end else begin
      seq_push(b, 1'b0);
    end
  endfunction

  // Link bytes caused by one accepted message byte; updates the predictor state.
  function automatic void frame_predict(input logic [7:0] d, input logic l);
    link_byte_t tail;
    seq_q.delete();
    if (!frame_open) begin
      seq_push(FLAG_BYTE, 1'b0);
      frame_open = 1'b1;
      fcs_acc    = 16'h0000;
    end
    seq_push_stuffed(d);
    fcs_acc = fcs_next(fcs_acc, d);
    if (l) begin
      seq_push_stuffed(fcs_acc[7:0]);
      seq_push_stuffed(fcs_acc[15:8]);
      seq_push(FLAG_BYTE, 1'b1);
      frame_open = 1'b0;
      fcs_acc    = 16'h0000;
    end
    tail = seq_q[$];
    tail.run_last = 1'b1;
    seq_q[seq_q.size() - 1] = tail;
  endfunction

  // Offer one byte at the falling edge and hold it until the transaction completes.
  task automatic offer_byte(input logic [7:0] d, input logic l);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    bytes_in++;
  endtask

  // Sender idles with valid low and junk on the data lines; n sets how long.
  task automatic sender_idle(input int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tlast  <= 1'($urandom);
    end
  endtask

  // Bursts of random length with random gaps in between; sometimes long unbroken stretches.
  task automatic pace_sender();
    if (burst_left == 0) begin
      sender_idle($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic send_predicted(input logic [7:0] d, input logic l);
    pace_sender();
    offer_byte(d, l);
    frame_predict(d, l);
    foreach (seq_q[k]) begin
      link_q.insert(link_q.size(), seq_q[k]);
    end
  endtask

  // Message bytes biased toward the ones that need stuffing and the extremes.
  function automatic logic [7:0] pick_octet();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      return FLAG_BYTE;
    end else if (sel < 6) begin
      return ESC_BYTE;
    end else if (sel == 6) begin
      return 8'h00;
    end else if (sel == 7) begin
      return 8'hFF;
    end else begin
      return 8'($urandom);
    end
  endfunction

  // Receiver: steps through four ready patterns in turn and takes one long hold-off.
  initial begin
    int cyc;
    int hold_left;
    bit held;
    cyc       = 0;
    hold_left = 0;
    held      = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!held && bytes_in >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case ((cyc / 40) % 4)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  // Compare each link transaction with the oldest predicted byte.
  always @(posedge clk) begin
    link_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      bytes_out++;
      if (m_tuser) begin
        frames_closed++;
      end
      if (m_tdata == ESC_BYTE) begin
        escapes_seen++;
      end
      if (link_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("%0t: unexpected link byte %h last=%b end=%b", $time, m_tdata, m_tlast,
                   m_tuser);
        end
      end else begin
        want = link_q.pop_front();
        if (m_tdata !== want.octet || m_tlast !== want.run_last ||
            m_tuser !== want.frame_end) begin
          errors++;
          if (errors <= MAX_SHOWN) begin
            $display("%0t: mismatch byte exp %h got %h, last exp %b got %b, end exp %b got %b",
                     $time, want.octet, m_tdata, want.run_last, m_tlast, want.frame_end,
                     m_tuser);
          end
        end
      end
    end
  end

  // Watchdog in case the block stops moving.
  initial begin
    #200000;
    $display("gdl90_frame_encoder test failed");
    $finish;
  end

  // Main sequence: reset, directed table, random messages, drain and verdict.
  initial begin
    dir_row_t    row;
    link_byte_t  hb;
    int          msg_len;
    int          drain;
    logic [7:0]  d;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = 8'h00;
    s_tlast       = 1'b0;
    fcs_acc       = 16'h0000;
    frame_open    = 1'b0;
    errors        = 0;
    bytes_in      = 0;
    bytes_out     = 0;
    frames_closed = 0;
    escapes_seen  = 0;
    burst_left    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: typed-in rows push their own link bytes, the rest use the predictor.
    for (int i = 0; i < N_DIR; i++) begin
      row = dir_tab[i];
      if (row.hand_n != 0) begin
        pace_sender();
        offer_byte(row.d, row.l);
        frame_predict(row.d, row.l);
        for (int k = 0; k < row.hand_n; k++) begin
          hb = '{row.hand[63 - 8 * k -: 8], k == row.hand_n - 1, k == row.hand_n - 1};
          link_q.insert(link_q.size(), hb);
        end
      end else begin
        send_predicted(row.d, row.l);
      end
    end

    // Random well-formed messages; a few are long, most are short.
    while (bytes_in < N_DIR + N_RANDOM) begin
      msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int k = 0; k < msg_len; k++) begin
        d = pick_octet();
        send_predicted(d, k == msg_len - 1);
      end
    end
    sender_idle(1);

    // Drain, then allow a few more cycles for anything stray.
    while (link_q.size() != 0) begin
      @(posedge clk);
    end
    drain = 0;
    while (drain < 20) begin
      @(posedge clk);
      drain++;
    end
    if (link_q.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted link bytes never arrived", $time, link_q.size());
    end

    $display("Framed %0d message bytes into %0d link bytes, %0d frames closed.",
             bytes_in, bytes_out, frames_closed);
    $display("Escape bytes on the link: %0d; one long output hold-off of %0d cycles.",
             escapes_seen, HOLD_LEN);
    if (errors == 0) begin
      $display("gdl90_frame_encoder test passed");
    end else begin
      $display("gdl90_frame_encoder test failed");
    end
    $finish;
  end

endmodule

### files.f
sv/gfe_pkg.sv
sv/gfe_front.sv
sv/gfe_stuffer.sv
sv/gdl90_frame_encoder.sv
sim/tb.sv
